// ===== rtl/srt_pkg.sv =====
// Shared types and constants for the shortest-remaining-time scheduler.
// No dependencies; imported by srt_ctrl, srt_dp and the top level.
package srt_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TIME_BITS_DEF   = 16;

  localparam int ID_W        = 8;
  localparam int FIELD_W     = 16;
  localparam int IN_TDATA_W  = ID_W + 2 * FIELD_W;
  localparam int OUT_TDATA_W = ID_W + FIELD_W;
  localparam int OUT_TUSER_W = 2;

  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_ARRIVE = 1'b1;

  typedef struct packed {
    logic load_item;
    logic do_arrival;
    logic do_tick;
    logic scan_init;
    logic read_step;
    logic scan_cmp;
    logic shift_init;
    logic shift_step;
    logic take_best;
    logic out_load;
  } srt_cmd_t;

  typedef struct packed {
    logic arrival;
    logic need_pick;
    logic table_empty;
    logic scan_last;
    logic shift_last;
    logic out_free;
  } srt_status_t;

endpackage

// ===== rtl/shortest_remaining_time_scheduler.sv =====
// Shortest-remaining-time scheduler: one running task plus a table of
// waiting tasks in a memory with one read and one write port, scanned by one comparator.
// Input beats on s_*, one result beat per input on m_*.
// Opcode on s_tuser: tick or task arrival; task fields on s_tdata.
// Each accepted beat yields exactly one result beat carrying the running
// task after that item and a dropped flag for a full table.
// Arrivals and ticks that need no pick go from accept through a decide step
// to the output register. A tick that picks from a non-empty table runs a
// scan and then a shift-down before the chosen entry becomes the running
// task: the comparator scans one entry per cycle, then the entries behind the
// chosen one move down one per cycle through the memory's single write port.
// One item is in work at a time; the next beat is taken as soon as the
// result is in the output register, even while it waits to be taken.
// If the receiver stalls with a result still held, the block finishes the
// current item and then holds it until the output register frees up.
// Reset (rst, synchronous) empties the table, clears the running task and
// drops any pending result beat.
module shortest_remaining_time_scheduler import srt_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,  // task_id, task_remaining, task_start
  input  logic                   s_tuser,  // opcode
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,  // running_id, running_remaining
  output logic [OUT_TUSER_W-1:0] m_tuser   // running_valid, dropped
);

  srt_cmd_t    cmd;
  srt_status_t status;

  srt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  srt_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  a_arrival_op: assert property (@(posedge clk) disable iff (rst)
    cmd.do_arrival |-> status.arrival)
    else $error("arrival step on a tick item");

  a_take_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.take_best |-> !status.table_empty)
    else $error("pick from an empty table");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("result beat overwritten before taken");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second beat accepted while an item is in work");

endmodule

// ===== rtl/srt_ctrl.sv =====
// Controller state machine for the scheduler: sequences decide, scan,
// shift-out and output steps. Depends on srt_pkg.
module srt_ctrl import srt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  srt_status_t status,
  output srt_cmd_t    cmd
);

  typedef enum logic [7:0] {
    S_IDLE       = 8'b0000_0001,
    S_DECIDE     = 8'b0000_0010,
    S_FILL       = 8'b0000_0100,
    S_SCAN       = 8'b0000_1000,
    S_SHIFT_SET  = 8'b0001_0000,
    S_SHIFT_FILL = 8'b0010_0000,
    S_SHIFT      = 8'b0100_0000,
    S_TAKE       = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   out_pend, out_pend_next;

  assign s_tready = (state == S_IDLE) && !out_pend;

  always_comb begin
    state_next    = state;
    out_pend_next = out_pend;
    cmd           = '0;
    if (out_pend) begin
      if (status.out_free) begin
        cmd.out_load  = 1'b1;
        out_pend_next = 1'b0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd.load_item = 1'b1;
            state_next    = S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (status.arrival) begin
            cmd.do_arrival = 1'b1;
            out_pend_next  = 1'b1;
            state_next     = S_IDLE;
          end else if (status.need_pick && !status.table_empty) begin
            cmd.scan_init = 1'b1;
            state_next    = S_FILL;
          end else begin
            cmd.do_tick   = 1'b1;
            out_pend_next = 1'b1;
            state_next    = S_IDLE;
          end
        end
        S_FILL: begin
          cmd.read_step = 1'b1;
          state_next    = S_SCAN;
        end
        S_SCAN: begin
          cmd.read_step = 1'b1;
          cmd.scan_cmp  = 1'b1;
          if (status.scan_last) state_next = S_SHIFT_SET;
        end
        S_SHIFT_SET: begin
          cmd.shift_init = 1'b1;
          state_next     = S_SHIFT_FILL;
        end
        S_SHIFT_FILL: begin
          cmd.read_step = 1'b1;
          state_next    = S_SHIFT;
        end
        S_SHIFT: begin
          cmd.read_step  = 1'b1;
          cmd.shift_step = 1'b1;
          if (status.shift_last) state_next = S_TAKE;
        end
        S_TAKE: begin
          cmd.take_best = 1'b1;
          out_pend_next = 1'b1;
          state_next    = S_IDLE;
        end
        default: state_next = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_pend <= 1'b0;
    end else begin
      state    <= state_next;
      out_pend <= out_pend_next;
    end
  end

endmodule

// ===== rtl/srt_dp.sv =====
// Datapath for the scheduler: running task, waiting table memory, scan
// comparator, shift-down path and output register. Depends on srt_pkg.
module srt_dp import srt_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tuser,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  srt_cmd_t               cmd,
  output srt_status_t            status,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic [OUT_TUSER_W-1:0] m_tuser
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

  typedef struct packed {
    logic [ID_W-1:0]      id;
    logic [TIME_BITS-1:0] left;
    logic [TIME_BITS-1:0] start;
  } entry_t;

  function automatic logic [TIME_BITS-1:0] to_time(input logic [FIELD_W-1:0] v);
    logic [TIME_BITS+FIELD_W-1:0] w;
    w = {{TIME_BITS{1'b0}}, v};
    return w[TIME_BITS-1:0];
  endfunction

  function automatic logic [FIELD_W-1:0] to_field(input logic [TIME_BITS-1:0] v);
    logic [TIME_BITS+FIELD_W-1:0] w;
    w = {{FIELD_W{1'b0}}, v};
    return w[FIELD_W-1:0];
  endfunction

  entry_t          mem [QUEUE_DEPTH];
  entry_t          mem_q;
  entry_t          item;
  logic            item_op;
  entry_t          run;
  logic            run_valid;
  entry_t          best;
  logic [CW-1:0]   best_idx;
  logic [CW-1:0]   count;
  logic [CW-1:0]   ptr;
  logic [CW-1:0]   q_idx;
  logic            drop;

  logic            full, preempt, better;
  logic [CW-1:0]   q_m1;
  logic [CW:0]     q_p1;
  logic            mem_we;
  logic [IW-1:0]   mem_waddr;
  entry_t          mem_wdata;

  assign full    = (count == FULL);
  assign preempt = (item.left < run.left);
  assign better  = (mem_q.left < best.left) ||
                   ((mem_q.left == best.left) && (mem_q.start < best.start));
  assign q_m1    = q_idx - 1'b1;
  assign q_p1    = {1'b0, q_idx} + 1'b1;

  assign status.arrival     = (item_op == OP_ARRIVE);
  assign status.need_pick   = !run_valid || (run.left == '0);
  assign status.table_empty = (count == '0);
  assign status.scan_last   = (q_idx == count - 1'b1);
  assign status.shift_last  = (q_p1 >= {1'b0, count});
  assign status.out_free    = !m_tvalid || m_tready;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count[IW-1:0];
    mem_wdata = preempt ? run : item;
    if (cmd.do_arrival && run_valid && !full) begin
      mem_we = 1'b1;
    end else if (cmd.shift_step && (q_idx < count)) begin
      mem_we    = 1'b1;
      mem_waddr = q_m1[IW-1:0];
      mem_wdata = mem_q;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_q <= mem[ptr[IW-1:0]];
    q_idx <= ptr;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_op    <= s_tuser;
      item.id    <= s_tdata[ID_W-1:0];
      item.left  <= to_time(s_tdata[ID_W+FIELD_W-1:ID_W]);
      item.start <= to_time(s_tdata[IN_TDATA_W-1:ID_W+FIELD_W]);
    end
    if (cmd.scan_init) ptr <= '0;
    else if (cmd.shift_init) ptr <= best_idx + 1'b1;
    else if (cmd.read_step) ptr <= ptr + 1'b1;
    if (cmd.scan_cmp && ((q_idx == '0) || better)) begin
      best     <= mem_q;
      best_idx <= q_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
      run       <= '0;
      count     <= '0;
      drop      <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cmd.load_item) drop <= 1'b0;
      if (cmd.do_arrival) begin
        if (!run_valid) begin
          run       <= item;
          run_valid <= 1'b1;
        end else begin
          if (preempt) run <= item;
          if (full) drop <= 1'b1;
          else count <= count + 1'b1;
        end
      end
      if (cmd.do_tick) begin
        if (status.need_pick) begin
          run_valid <= 1'b0;
          run       <= '0;
        end else begin
          run.left <= run.left - 1'b1;
        end
      end
      if (cmd.take_best) begin
        run.id    <= best.id;
        run.start <= best.start;
        run.left  <= (best.left != '0) ? best.left - 1'b1 : best.left;
        run_valid <= 1'b1;
        count     <= count - 1'b1;
      end
      if (cmd.out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= run_valid ? {to_field(run.left), run.id} : '0;
      m_tuser <= {drop, run_valid};
    end
  end

endmodule
